FILE: rtl/fdnd_pkg.sv
// Shared types and constants of the FAT directory entry name decoder.
// No dependencies; the parser, the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package fdnd_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int CHUNK_BYTES = 8;
  localparam int LFN_CHARS   = 13;
  localparam int LFN_STRIDE  = 13;

  localparam logic [7:0] FIRST_END     = 8'h00;
  localparam logic [7:0] FIRST_DELETED = 8'hE5;
  localparam logic [7:0] KANJI_ESC     = 8'h05;
  localparam logic [7:0] ATTR_LFN      = 8'h0F;
  localparam logic [7:0] SEQ_MASK      = 8'h1F;
  localparam logic [7:0] LFN_FIRST_BIT = 8'h40;
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_PAD      = 8'hFF;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DOT      = 8'h2E;
  localparam logic [7:0] NT_LOWER_BASE = 8'h08;
  localparam logic [7:0] NT_LOWER_EXT  = 8'h10;
  localparam logic [7:0] CASE_DIFF     = 8'd32;

  localparam logic KIND_NAME = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // entry byte offsets of the low bytes of the 13 UTF-16 characters
  localparam logic [4:0] LFN_POS [LFN_CHARS] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
  };

  typedef struct packed {
    logic             is_end;
    logic             is_deleted;
    logic             is_lfn;
    logic             lfn_first;
    logic [4:0]       seq;
    logic [12:0][7:0] lfn_chars;
    logic [3:0]       lfn_count;
    logic [11:0][7:0] short_name;
    logic [3:0]       short_len;
    logic [7:0]       attr;
  } fdnd_entry_t;

  function automatic logic [7:0] lower_if(input logic [7:0] c, input logic lower);
    if (lower && c >= "A" && c <= "Z") begin
      return c + CASE_DIFF;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fdnd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fdnd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fdnd_entry_parse.sv
// Entry classifier: packs long-name characters and builds the 8.3 short name.
// Depends on fdnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdnd_entry_parse (
  input  wire logic [63:0]         entry_word0,
  input  wire logic [63:0]         entry_word1,
  input  wire logic [63:0]         entry_word2,
  input  wire logic [63:0]         entry_word3,
  output fdnd_pkg::fdnd_entry_t    info
);
  import fdnd_pkg::*;

  logic [31:0][7:0] eb;
  assign eb = {entry_word3, entry_word2, entry_word1, entry_word0};

  // classify and pack long-name characters, dropping pad and zero bytes
  always_comb begin
    logic [3:0]       cnt;
    logic [7:0]       c;
    logic [3:0]       lb;
    logic [1:0]       le;
    logic             stop;
    logic             has_ext;
    logic [3:0]       e;
    logic [7:0]       nt;
    info = '0;
    info.is_end     = (eb[0] == FIRST_END);
    info.is_deleted = (eb[0] == FIRST_DELETED);
    info.is_lfn     = (eb[11] == ATTR_LFN);
    info.lfn_first  = |(eb[0] & LFN_FIRST_BIT);
    info.seq        = 5'(eb[0] & SEQ_MASK);
    info.attr       = eb[11];
    nt              = eb[12];

    cnt = '0;
    for (int i = 0; i < LFN_CHARS; i++) begin
      c = eb[LFN_POS[i]];
      if (c != CHAR_NUL && c != CHAR_PAD) begin
        info.lfn_chars[cnt] = c;
        cnt = cnt + 4'd1;
      end
    end
    info.lfn_count = cnt;

    // base length and extension length up to the first space or zero
    lb = 4'd8;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && (eb[i] == CHAR_SPACE || eb[i] == CHAR_NUL)) begin
        lb = 4'(i);
        stop = 1'b1;
      end
    end
    le = 2'd3;
    stop = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!stop && (eb[8 + i] == CHAR_SPACE || eb[8 + i] == CHAR_NUL)) begin
        le = 2'(i);
        stop = 1'b1;
      end
    end
    has_ext = (eb[8] != CHAR_SPACE) && (eb[8] != CHAR_NUL);

    // assemble base, dot and extension
    for (int p = 0; p < 12; p++) begin
      e = 4'(p) - lb - 4'd1;
      if (4'(p) < lb) begin
        c = eb[p];
        if (p == 0 && c == KANJI_ESC) begin
          c = FIRST_DELETED;
        end
        info.short_name[p] = lower_if(c, |(nt & NT_LOWER_BASE));
      end else if (has_ext && 4'(p) == lb) begin
        info.short_name[p] = CHAR_DOT;
      end else if (has_ext && 4'(p) > lb && e < {2'b00, le}) begin
        info.short_name[p] = lower_if(eb[5'd8 + 5'(e)], |(nt & NT_LOWER_EXT));
      end
    end
    info.short_len = lb + (has_ext ? (4'd1 + {2'b00, le}) : 4'd0);
  end

endmodule

`default_nettype wire

FILE: rtl/fat_dir_entry_name_decoder_unit.sv
// FAT directory entry name decoder: top level with the name-store sequencer.
// Depends on fdnd_pkg, fdnd_ram and fdnd_entry_parse.
//
// One 32-byte directory entry is taken per request; results leave through a
// single output register, so a new request is taken while the last result of
// the previous one still waits. A deleted entry gives no result. A long-name
// entry touches at most three name-store rows: each row is read, merged and
// written back by the sequencer, which also keeps read and write of a row
// apart. A long-name entry with sequence number zero or no characters writes
// nothing. A short-name entry gives one or two results, the end marker one.
// A regular entry whose name comes from the store reads one 8-byte row per
// chunk and looks one row ahead to find the end. Each row has a valid bit
// that reset and the long-name start flag clear at once, so no clearing pass
// is needed.
`timescale 1ns / 1ps
`default_nettype none

module fat_dir_entry_name_decoder_unit #(
  parameter int NAME_STORE_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] entry_word0,
  input  wire logic [63:0] entry_word1,
  input  wire logic [63:0] entry_word2,
  input  wire logic [63:0] entry_word3,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [63:0]      name_chunk,
  output logic [3:0]       chunk_chars,
  output logic             from_long_name,
  output logic [7:0]       entry_attributes,
  output logic             last
);
  import fdnd_pkg::*;

  localparam int ROWS   = (NAME_STORE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int RAW    = $clog2(ROWS);
  localparam int LIMIT  = (NAME_STORE_BYTES < MAX_RESULTS * CHUNK_BYTES) ?
                          NAME_STORE_BYTES : MAX_RESULTS * CHUNK_BYTES;
  localparam int LROWS  = (LIMIT + CHUNK_BYTES - 1) / CHUNK_BYTES;

  typedef enum logic [3:0] {
    S_IDLE, S_END, S_SH0, S_SH1, S_LFN_RD, S_LFN_WR,
    S_LN_WAIT0, S_LN_EVAL, S_LN_WAITN, S_LN_EMIT
  } state_t;

  state_t           state;
  fdnd_entry_t      info;
  fdnd_entry_t      ent;
  logic             long_active;
  logic [ROWS-1:0]  row_valid;
  logic             rd_vld;
  logic [8:0]       lbase;
  logic [7:0]       lrow;
  logic [RAW-1:0]   cur_row;
  logic [7:0][7:0]  cur;
  logic [7:0][7:0]  nxt;
  logic             last_r;

  logic             accept;
  logic             can_load;
  logic             ram_we;
  logic             ram_re;
  logic [RAW-1:0]   ram_raddr;
  logic [63:0]      ram_rdata;
  logic [7:0][7:0]  rd_row;
  logic [7:0][7:0]  merged;
  logic [3:0]       cur_cnt;
  logic [7:0][7:0]  cur_chunk;
  logic [8:0]       base_calc;
  logic [9:0]       lend;

  fdnd_entry_parse u_parse (
    .entry_word0 (entry_word0),
    .entry_word1 (entry_word1),
    .entry_word2 (entry_word2),
    .entry_word3 (entry_word3),
    .info        (info)
  );

  fdnd_ram #(
    .WIDTH (64),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lrow[RAW-1:0]),
    .wdata (merged),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid || out_ready;
  assign rd_row    = rd_vld ? ram_rdata : '0;
  assign base_calc = ({4'b0000, info.seq} - 9'd1) * 9'(LFN_STRIDE);
  assign lend      = {1'b0, lbase} + {6'b0, ent.lfn_count} - 10'd1;

  // select the store read: first row of a long name, the next row, or a merge row
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        ram_re = accept && !info.is_end && !info.is_deleted && !info.is_lfn && long_active;
      end
      S_LFN_RD: begin
        ram_re    = ({2'b00, lrow} < 10'(ROWS)) && ({lrow, 3'b000} <= {1'b0, lend});
        ram_raddr = lrow[RAW-1:0];
      end
      S_LN_EVAL: begin
        ram_re    = (cur_cnt == 4'd8) && (cur_row != RAW'(LROWS - 1));
        ram_raddr = cur_row + RAW'(1);
      end
      default: begin
      end
    endcase
  end

  // merge packed long-name bytes into the row just read
  always_comb begin
    logic [10:0] p;
    logic [10:0] j;
    for (int l = 0; l < 8; l++) begin
      p = {lrow, 3'(l)};
      j = p - {2'b00, lbase};
      merged[l] = rd_row[l];
      if (p >= {2'b00, lbase} && j < {7'b0, ent.lfn_count} &&
          p < 11'(NAME_STORE_BYTES)) begin
        merged[l] = ent.lfn_chars[j[3:0]];
      end
    end
  end
  assign ram_we = (state == S_LFN_WR);

  // length of the current row up to its first zero byte
  always_comb begin
    logic stop;
    cur_cnt = 4'd8;
    stop = 1'b0;
    cur_chunk = '0;
    for (int l = 0; l < 8; l++) begin
      if (!stop && cur[l] == CHAR_NUL) begin
        cur_cnt = 4'(l);
        stop = 1'b1;
      end
      if (!stop) begin
        cur_chunk[l] = cur[l];
      end
    end
  end

  // sequencer, store valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      long_active <= 1'b0;
      row_valid   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_re) begin
        rd_vld <= row_valid[ram_raddr];
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ent <= info;
            priority if (info.is_end) begin
              long_active <= 1'b0;
              state       <= S_END;
            end else if (info.is_deleted) begin
              state <= S_IDLE;
            end else if (info.is_lfn) begin
              long_active <= 1'b1;
              if (info.lfn_first) begin
                row_valid <= '0;
              end
              lbase <= base_calc;
              lrow  <= {2'b00, base_calc[8:3]};
              if (info.seq != 5'd0 && info.lfn_count != 4'd0) begin
                state <= S_LFN_RD;
              end
            end else begin
              long_active    <= 1'b0;
              cur_row        <= '0;
              state          <= long_active ? S_LN_WAIT0 : S_SH0;
            end
          end
        end
        S_END: begin
          if (can_load) begin
            out_valid        <= 1'b1;
            kind             <= KIND_END;
            name_chunk       <= '0;
            chunk_chars      <= '0;
            from_long_name   <= 1'b0;
            entry_attributes <= '0;
            last             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_SH0: begin
          if (can_load) begin
            out_valid        <= 1'b1;
            kind             <= KIND_NAME;
            name_chunk       <= ent.short_name[7:0];
            chunk_chars      <= (ent.short_len > 4'd8) ? 4'd8 : ent.short_len;
            from_long_name   <= 1'b0;
            entry_attributes <= ent.attr;
            last             <= (ent.short_len <= 4'd8);
            state            <= (ent.short_len > 4'd8) ? S_SH1 : S_IDLE;
          end
        end
        S_SH1: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            name_chunk  <= {32'b0, ent.short_name[11:8]};
            chunk_chars <= ent.short_len - 4'd8;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_LFN_RD: begin
          state <= ram_re ? S_LFN_WR : S_IDLE;
        end
        S_LFN_WR: begin
          row_valid[lrow[RAW-1:0]] <= 1'b1;
          lrow  <= lrow + 8'd1;
          state <= S_LFN_RD;
        end
        S_LN_WAIT0: begin
          cur   <= rd_row;
          state <= S_LN_EVAL;
        end
        S_LN_EVAL: begin
          if (ram_re) begin
            state <= S_LN_WAITN;
          end else begin
            last_r <= 1'b1;
            state  <= S_LN_EMIT;
          end
        end
        S_LN_WAITN: begin
          nxt    <= rd_row;
          last_r <= (rd_row[0] == CHAR_NUL);
          state  <= S_LN_EMIT;
        end
        S_LN_EMIT: begin
          if (can_load) begin
            out_valid        <= 1'b1;
            kind             <= KIND_NAME;
            name_chunk       <= cur_chunk;
            chunk_chars      <= cur_cnt;
            from_long_name   <= 1'b1;
            entry_attributes <= ent.attr;
            last             <= last_r;
            if (last_r) begin
              state <= S_IDLE;
            end else begin
              cur     <= nxt;
              cur_row <= cur_row + RAW'(1);
              state   <= S_LN_EVAL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a merge write never meets a read of the same row
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (lrow[RAW-1:0] == ram_raddr)))
    else $error("store read and write of one row in the same cycle");

  // chunk size stays within one chunk
  a_chars_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chunk_chars <= 4'd8))
    else $error("chunk_chars out of range");

  // end marker is always the only result of its request
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_END) |-> last)
    else $error("end marker without last");

  // a short chunk ends the name
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NAME && chunk_chars != 4'd8) |-> last)
    else $error("partial chunk not marked last");

  // after a long-name row that is not the last is shown, the next row is evaluated
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_LN_EMIT && can_load && !last_r) |=> (state == S_LN_EVAL))
    else $error("long-name sequencer skipped a row");

endmodule

`default_nettype wire

FILE: verif/fat_dir_entry_name_decoder_unit_tb.sv
// Self-checking testbench for the FAT directory entry name decoder.
// Depends on fdnd_pkg and the RTL; directed cases first, then random entry streams.
`timescale 1ns / 1ps

module fat_dir_entry_name_decoder_unit_tb;
  import fdnd_pkg::*;

  localparam int STORE_BYTES = 256;

  typedef struct packed {
    logic        kind;
    logic [63:0] chunk;
    logic [3:0]  chars;
    logic        from_long;
    logic [7:0]  attr;
    logic        last;
  } name_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] entry_word0 = '0;
  logic [63:0] entry_word1 = '0;
  logic [63:0] entry_word2 = '0;
  logic [63:0] entry_word3 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [63:0] name_chunk;
  logic [3:0]  chunk_chars;
  logic        from_long_name;
  logic [7:0]  entry_attributes;
  logic        last;

  fat_dir_entry_name_decoder_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .entry_word0(entry_word0), .entry_word1(entry_word1),
    .entry_word2(entry_word2), .entry_word3(entry_word3),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .name_chunk(name_chunk), .chunk_chars(chunk_chars),
    .from_long_name(from_long_name), .entry_attributes(entry_attributes),
    .last(last)
  );

  // predictor state
  logic [7:0]   name_store [STORE_BYTES];
  logic         long_open;
  name_result_t pending_chunks [$];
  int           error_count = 0;
  int           counted_entries = 0;
  int           burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c, input logic en);
    return (en && c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  function automatic logic [255:0] rand_entry();
    logic [255:0] e;
    for (int i = 0; i < 8; i++) e[32*i+:32] = $urandom;
    return e;
  endfunction

  // Compute the chunks that one entry causes and advance the predictor state.
  task automatic predict_names(input logic [255:0] e);
    logic [7:0]   first, attr, nt, c;
    logic [7:0]   nm [STORE_BYTES];
    int           base, idx, pos, len, chunks;
    bit           stop, from_long;
    name_result_t r;
    first = e[7:0];
    attr = e[95:88];
    nt = e[103:96];
    len = 0;
    if (first == FIRST_END) begin
      long_open = 1'b0;
      r = '{kind: KIND_END, chunk: '0, chars: '0, from_long: 1'b0, attr: '0, last: 1'b1};
      pending_chunks.push_back(r);
    end else if (first == FIRST_DELETED) begin
      // drop: no result, no state change
    end else if (attr == ATTR_LFN) begin
      base = (int'(first & SEQ_MASK) - 1) * LFN_STRIDE;
      idx = 0;
      if ((first & LFN_FIRST_BIT) != 0) begin
        foreach (name_store[i]) name_store[i] = 8'h00;
      end
      for (int i = 0; i < LFN_CHARS; i++) begin
        c = e[8*LFN_POS[i]+:8];
        if (c != CHAR_NUL && c != CHAR_PAD) begin
          pos = base + idx;
          if (pos >= 0 && pos < STORE_BYTES) name_store[pos] = c;
          idx++;
        end
      end
      long_open = 1'b1;
    end else begin
      from_long = long_open;
      if (from_long) begin
        while (len < STORE_BYTES && len < MAX_RESULTS * CHUNK_BYTES
               && name_store[len] != 8'h00) begin
          nm[len] = name_store[len];
          len++;
        end
      end else begin
        stop = 0;
        for (int i = 0; i < 8; i++) begin
          c = e[8*i+:8];
          if (c == CHAR_SPACE || c == CHAR_NUL) stop = 1;
          if (!stop) begin
            if (i == 0 && c == KANJI_ESC) c = FIRST_DELETED;
            nm[len] = to_lower(c, (nt & NT_LOWER_BASE) != 0);
            len++;
          end
        end
        if (e[71:64] != CHAR_SPACE && e[71:64] != CHAR_NUL) begin
          nm[len] = CHAR_DOT;
          len++;
          stop = 0;
          for (int i = 8; i < 11; i++) begin
            c = e[8*i+:8];
            if (c == CHAR_SPACE || c == CHAR_NUL) stop = 1;
            if (!stop) begin
              nm[len] = to_lower(c, (nt & NT_LOWER_EXT) != 0);
              len++;
            end
          end
        end
      end
      chunks = (len == 0) ? 1 : (len + 7) / 8;
      for (int k = 0; k < chunks; k++) begin
        r = '{kind: KIND_NAME, chunk: '0, chars: '0, from_long: from_long, attr: attr,
              last: (k == chunks - 1)};
        for (int i = 0; i < 8; i++) begin
          if (k * 8 + i < len) begin
            r.chunk[8*i+:8] = nm[k*8+i];
            r.chars = r.chars + 4'd1;
          end
        end
        pending_chunks.push_back(r);
      end
      long_open = 1'b0;
    end
  endtask

  // Send one entry: sometimes idle between bursts, then hold until accepted.
  task automatic send_entry(input logic [255:0] e);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    entry_word0 <= e[63:0];
    entry_word1 <= e[127:64];
    entry_word2 <= e[191:128];
    entry_word3 <= e[255:192];
    do @(posedge clk); while (!in_ready);
    predict_names(e);
    if (e[7:0] != FIRST_DELETED) counted_entries++;
  endtask

  // Hold off the sender until every outstanding chunk has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_chunks.size() != 0) @(negedge clk);
  endtask

  function automatic logic [255:0] short_entry(input logic [87:0] nm11,
                                               input logic [7:0] attr, input logic [7:0] nt);
    logic [255:0] e;
    e = rand_entry();
    for (int i = 0; i < 11; i++) e[8*i+:8] = nm11[8*(10-i)+:8];
    e[95:88] = attr;
    e[103:96] = nt;
    return e;
  endfunction

  function automatic logic [255:0] lfn_entry(input logic [7:0] ord, input logic [103:0] txt);
    logic [255:0] e;
    e = rand_entry();
    e[7:0] = ord;
    e[95:88] = ATTR_LFN;
    for (int i = 0; i < LFN_CHARS; i++) e[8*LFN_POS[i]+:8] = txt[8*(12-i)+:8];
    return e;
  endfunction

  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range("A", "Z"));
      5, 6:          return 8'($urandom_range("a", "z"));
      7:             return 8'($urandom_range("0", "9"));
      default:       return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [255:0] rand_short();
    logic [87:0] nm;
    int          blen, xlen;
    blen = $urandom_range(0, 8);
    xlen = $urandom_range(0, 3);
    for (int i = 0; i < 11; i++) begin
      if ((i < 8 && i < blen) || (i >= 8 && i - 8 < xlen)) nm[8*(10-i)+:8] = name_char();
      else nm[8*(10-i)+:8] = ($urandom_range(0, 3) == 0) ? CHAR_NUL : CHAR_SPACE;
    end
    if (nm[87:80] == FIRST_DELETED || nm[87:80] == FIRST_END) nm[87:80] = "X";
    if ($urandom_range(0, 15) == 0) nm[87:80] = KANJI_ESC;
    return short_entry(nm, 8'($urandom_range(0, 255)) & 8'hEF | 8'($urandom_range(0, 1)),
                       8'($urandom));
  endfunction

  function automatic logic [255:0] rand_lfn(input logic [7:0] ord);
    logic [103:0] t;
    int           used;
    used = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 13;
    for (int i = 0; i < 13; i++) begin
      if (i < used) t[8*(12-i)+:8] = name_char();
      else if (i == used) t[8*(12-i)+:8] = CHAR_NUL;
      else t[8*(12-i)+:8] = CHAR_PAD;
      if (i < used && $urandom_range(0, 30) == 0) t[8*(12-i)+:8] = CHAR_PAD;
    end
    return lfn_entry(ord, t);
  endfunction

  task automatic test_end_and_deleted();
    logic [255:0] e;
    e = rand_entry(); e[7:0] = FIRST_END;
    send_entry(e);
    e = short_entry("DELETED TXT", 8'h20, 8'h00); e[7:0] = FIRST_DELETED;
    send_entry(e);
    e = lfn_entry(8'h41, "gone.txt\0\377\377\377\377"); e[7:0] = FIRST_DELETED;
    send_entry(e);
  endtask

  task automatic test_short_names();
    send_entry(short_entry("README  TXT", 8'h20, 8'h00));
    send_entry(short_entry("README  TXT", 8'h01, NT_LOWER_BASE));
    send_entry(short_entry("MAKEFILEMK ", 8'h10, NT_LOWER_EXT));
    send_entry(short_entry("MiXeD9Z@A[z", 8'hFF, NT_LOWER_BASE | NT_LOWER_EXT));
    send_entry(short_entry({KANJI_ESC, "ABC    DAT"}, 8'h00, 8'h00));
    send_entry(short_entry("           ", 8'h08, 8'h00));
    send_entry(short_entry("        TXT", 8'h20, 8'h00));
    send_entry(short_entry({8'hFF, 8'h80, "B\0XYZ\0\0\377\377"}, 8'hFE, 8'hE7));
  endtask

  task automatic test_long_names();
    logic [255:0] e;
    send_entry(lfn_entry(8'h41, "hello.c\0\377\377\377\377\377"));
    send_entry(short_entry("HELLO   C  ", 8'h20, 8'h00));
    send_entry(lfn_entry(8'h42, "_long_file_na"));
    send_entry(lfn_entry(8'h01, "A very\377 long."));
    send_entry(short_entry("AVERYL~1   ", 8'h20, 8'h00));
    // sequence zero writes below the store, nothing kept
    send_entry(lfn_entry(8'h40, "zero-seq-name"));
    send_entry(short_entry("ZERO       ", 8'h10, 8'h00));
    // no start flag: write over what the store still holds
    send_entry(lfn_entry(8'h1F, "out-of-store!"));
    send_entry(lfn_entry(8'h01, "ab\0\0\0\0\0\0\0\0\0\0\0"));
    send_entry(short_entry("AB         ", 8'h00, 8'h00));
    // end marker cancels an open long name
    send_entry(lfn_entry(8'h41, "stale\0\377\377\377\377\377\377\377"));
    e = rand_entry(); e[7:0] = FIRST_END;
    send_entry(e);
    send_entry(short_entry("FRESH   BIN", 8'h20, 8'h00));
    wait_drained();
  endtask

  task automatic test_full_store();
    for (int s = 20; s >= 1; s--) begin
      send_entry(lfn_entry(8'(s) | (s == 20 ? LFN_FIRST_BIT : 8'h00), "0123456789abc"));
    end
    send_entry(short_entry("FULLSTORTXT", 8'h20, 8'h00));
    wait_drained();
  endtask

  task automatic test_random_streams();
    logic [255:0] e;
    int           roll, parts;
    while (counted_entries < 430) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        parts = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 21) : $urandom_range(1, 4);
        for (int s = parts; s >= 1; s--) begin
          if ($urandom_range(0, 19) != 0) begin
            send_entry(rand_lfn(8'(s) | (s == parts ? LFN_FIRST_BIT : 8'h00)));
          end
        end
        send_entry(rand_short());
      end else if (roll < 80) begin
        send_entry(rand_short());
      end else if (roll < 85) begin
        e = ($urandom_range(0, 1) == 0) ? rand_lfn(8'h41) : rand_short();
        e[7:0] = FIRST_DELETED;
        send_entry(e);
      end else if (roll < 88) begin
        e = rand_entry(); e[7:0] = FIRST_END;
        send_entry(e);
      end else if (roll < 92) begin
        send_entry(rand_lfn(8'($urandom_range(0, 255))));
      end else begin
        send_entry(rand_entry());
      end
      if ($urandom_range(0, 60) == 0) wait_drained();
    end
  endtask

  // Stall the result side on a pattern drawn at random: always ready, alternating, random, or a ready window.
  int stall_cycle = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= stall_cycle[0];
      2:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_cycle % 16) >= 10;
    endcase
  end

  // Compare each accepted chunk with the oldest expectation.
  always @(posedge clk) begin
    name_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chunks.size() == 0) begin
        $error("unexpected result: kind=%0d chunk=%h", kind, name_chunk);
        error_count++;
      end else begin
        want = pending_chunks.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          error_count++;
        end
        if (name_chunk !== want.chunk) begin
          $error("name_chunk: expected %h, got %h", want.chunk, name_chunk);
          error_count++;
        end
        if (chunk_chars !== want.chars) begin
          $error("chunk_chars: expected %0d, got %0d", want.chars, chunk_chars);
          error_count++;
        end
        if (from_long_name !== want.from_long) begin
          $error("from_long_name: expected %0d, got %0d", want.from_long, from_long_name);
          error_count++;
        end
        if (entry_attributes !== want.attr) begin
          $error("entry_attributes: expected %h, got %h", want.attr, entry_attributes);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          error_count++;
        end
      end
    end
  end

  initial begin
    foreach (name_store[i]) name_store[i] = 8'h00;
    long_open = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_end_and_deleted();
    test_short_names();
    test_long_names();
    test_full_store();
    test_random_streams();
    wait_drained();
    repeat (200) @(negedge clk);
    if (error_count == 0 && pending_chunks.size() == 0) begin
      $display("fat_dir_entry_name_decoder_unit verification clean");
    end else begin
      $display("fat_dir_entry_name_decoder_unit verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("fat_dir_entry_name_decoder_unit verification failed");
    $finish;
  end

endmodule
